FILE: src/bcr_pkg.sv
`timescale 1ns / 1ps

package bcr_pkg;

  // Operation codes carried on func_i
  localparam logic [2:0] FUNC_FILL_SET = 3'd0;
  localparam logic [2:0] FUNC_FILL_TOG = 3'd1;
  localparam logic [2:0] FUNC_RING_SET = 3'd2;
  localparam logic [2:0] FUNC_READ     = 3'd3;
  localparam logic [2:0] FUNC_WRITE    = 3'd4;

  // Clipped coordinates: x <= 255 + 127, y <= 127 + 127
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  // Shared multiplier operands cover the image width up to 1024
  localparam int MUL_W   = 11;
  localparam int PROD_W  = 2 * MUL_W;
  // Squares and the ring band: at most 2 * 127 * 127
  localparam int SQ_W    = 15;
  localparam int SLACK_W = SQ_W + 2;
  // Delta magnitudes never exceed the radius
  localparam int DELTA_W = 7;

  // Pixel bit position inside a byte, most significant bit first
  localparam logic [2:0] BIT_TOP = 3'd7;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RR,
    ST_BAND,
    ST_BASE,
    ST_ROW,
    ST_RD,
    ST_LD,
    ST_PIX,
    ST_WR,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic in_circle;
    logic in_band;
  } hit_t;

endpackage

FILE: src/bcr_store.sv
`timescale 1ns / 1ps

module bcr_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bcr_dist.sv
`timescale 1ns / 1ps

module bcr_dist (
  input  logic [bcr_pkg::MUL_W-1:0]  mul_a_i,
  input  logic [bcr_pkg::MUL_W-1:0]  mul_b_i,
  input  logic [bcr_pkg::SQ_W-1:0]   rr_i,
  input  logic [bcr_pkg::SQ_W-1:0]   dy2_i,
  input  logic [bcr_pkg::SQ_W-1:0]   band_i,
  output logic [bcr_pkg::PROD_W-1:0] prod_o,
  output bcr_pkg::hit_t              hit_o
);

  localparam int PROD_W = bcr_pkg::PROD_W;

  logic signed [bcr_pkg::SLACK_W-1:0] slack;

  // Shared multiplier: squares, r*r, r*t and the row base
  assign prod_o = PROD_W'(mul_a_i) * PROD_W'(mul_b_i);

  // Slack against the circle, valid when prod_o holds dx squared
  assign slack = $signed({2'b00, rr_i}) - $signed({2'b00, dy2_i})
               - $signed({2'b00, prod_o[bcr_pkg::SQ_W-1:0]});

  assign hit_o.in_circle = ~slack[bcr_pkg::SLACK_W-1];
  assign hit_o.in_band   = slack <= $signed({2'b00, band_i});

endmodule

FILE: src/bitmap_circle_rasterizer_top.sv
`timescale 1ns / 1ps

// One-bit-per-pixel image of IMAGE_WIDTH x IMAGE_HEIGHT pixels, packed eight to a byte in
// row-major order with the most significant bit first, drawn into by filled and ring
// circles and reachable byte by byte. An item transfers at a clock edge with start high
// and busy low. After reset the block sweeps the image to zero, one byte a cycle, and busy
// stays high until all (IMAGE_WIDTH*IMAGE_HEIGHT+7)/8 bytes (1024 at the default size) are
// cleared. A write goes to the store in the accepting cycle and leaves busy low. A read
// returns its byte in the cycle right after the transfer: read_valid_o is high for exactly
// one cycle with read_byte_o, and the receiver cannot stall it, so capture it then. A draw
// walks the bounding box clipped to the image, one pixel a cycle outside its byte and row
// steps, and shares a single multiplier for r*r, 2*r*t, the row base, dy squared once per
// row and dx squared once per pixel. Each image byte the walk touches costs a read, a load
// and a write-back step around its pixels, and each row one more step. A box lying wholly
// outside the image and an unknown func code are dropped at once without going busy.
module bitmap_circle_rasterizer_top #(
  parameter int IMAGE_WIDTH  = 128,
  parameter int IMAGE_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [7:0]  center_x_i,
  input  logic [6:0]  center_y_i,
  input  logic [6:0]  radius_i,
  input  logic [6:0]  ring_thickness_i,
  input  logic [9:0]  byte_address_i,
  input  logic [7:0]  write_byte_i,
  output logic        read_valid_o,
  output logic [7:0]  read_byte_o
);

  localparam int NPIX        = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int STORE_BYTES = (NPIX + 7) / 8;
  localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PW          = AW + 3;
  localparam int X_W         = bcr_pkg::X_W;
  localparam int Y_W         = bcr_pkg::Y_W;
  localparam int MUL_W       = bcr_pkg::MUL_W;
  localparam int SQ_W        = bcr_pkg::SQ_W;
  localparam int DELTA_W     = bcr_pkg::DELTA_W;

  bcr_pkg::state_e state_q, state_d;

  logic [AW-1:0]   clr_q, clr_d;
  logic [2:0]      func_q, func_d;
  logic [7:0]      cx_q, cx_d;
  logic [6:0]      cy_q, cy_d;
  logic [6:0]      r_q, r_d;
  logic [6:0]      t_q, t_d;
  logic [X_W-1:0]  x0_q, x0_d;
  logic [X_W-1:0]  x1_q, x1_d;
  logic [X_W-1:0]  x_q, x_d;
  logic [Y_W-1:0]  y1_q, y1_d;
  logic [Y_W-1:0]  y_q, y_d;
  logic            rd_ok_q, rd_ok_d;
  logic [SQ_W-1:0] rr_q, rr_d;
  logic [SQ_W-1:0] band_q, band_d;
  logic [SQ_W-1:0] dy2_q, dy2_d;
  logic [PW-1:0]   base_q, base_d;
  logic [7:0]      work_q, work_d;

  // Handshake and decode
  logic accept;
  logic is_draw;
  logic is_read;
  logic is_write;
  logic addr_ok;

  // Clipping of an incoming draw
  logic [X_W-1:0] sum_x;
  logic [X_W-1:0] x0_in;
  logic [X_W-1:0] x1_in;
  logic [Y_W-1:0] sum_y;
  logic [Y_W-1:0] y0_in;
  logic [Y_W-1:0] y1_in;
  logic           box_empty;

  // Walk position
  logic [PW-1:0]          pix;
  logic [AW-1:0]          byte_idx;
  logic [2:0]             bit_sel;
  logic                   row_end;
  logic                   byte_end;
  logic signed [X_W:0]    dx_s;
  logic signed [Y_W:0]    dy_s;
  logic [DELTA_W-1:0]     dx_abs;
  logic [DELTA_W-1:0]     dy_abs;
  logic                   hit;

  // Shared unit and memory ports
  logic [MUL_W-1:0]          mul_a;
  logic [MUL_W-1:0]          mul_b;
  logic [bcr_pkg::PROD_W-1:0] prod;
  bcr_pkg::hit_t             dist_hit;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [7:0]                mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [7:0]                mem_rdata;

  assign busy   = (state_q != bcr_pkg::ST_IDLE);
  assign accept = start & ~busy;

  always_comb begin
    is_draw  = 1'b0;
    is_read  = 1'b0;
    is_write = 1'b0;
    unique case (func_i) inside
      bcr_pkg::FUNC_FILL_SET, bcr_pkg::FUNC_FILL_TOG, bcr_pkg::FUNC_RING_SET: is_draw = 1'b1;
      bcr_pkg::FUNC_READ:  is_read  = 1'b1;
      bcr_pkg::FUNC_WRITE: is_write = 1'b1;
      default: ;
    endcase
  end

  assign addr_ok = int'(byte_address_i) < STORE_BYTES;

  // Clip the bounding box to the image
  assign sum_x = X_W'(center_x_i) + X_W'(radius_i);
  assign x0_in = (center_x_i >= 8'(radius_i)) ? X_W'(center_x_i - 8'(radius_i)) : '0;
  assign x1_in = (int'(sum_x) > IMAGE_WIDTH - 1) ? X_W'(IMAGE_WIDTH - 1) : sum_x;
  assign sum_y = Y_W'(center_y_i) + Y_W'(radius_i);
  assign y0_in = (center_y_i >= radius_i) ? Y_W'(center_y_i - radius_i) : '0;
  assign y1_in = (int'(sum_y) > IMAGE_HEIGHT - 1) ? Y_W'(IMAGE_HEIGHT - 1) : sum_y;
  assign box_empty = (int'(x0_in) >= IMAGE_WIDTH) || (int'(y0_in) >= IMAGE_HEIGHT);

  // Current pixel and its byte
  assign pix      = base_q + PW'(x_q);
  assign byte_idx = pix[PW-1:3];
  assign bit_sel  = bcr_pkg::BIT_TOP - pix[2:0];
  assign row_end  = (x_q == x1_q);
  assign byte_end = row_end || (pix[2:0] == bcr_pkg::BIT_TOP);

  // Distances from the centre never exceed the radius inside the box
  assign dx_s   = $signed({1'b0, x_q}) - $signed((X_W+1)'(cx_q));
  assign dy_s   = $signed({1'b0, y_q}) - $signed((Y_W+1)'(cy_q));
  assign dx_abs = dx_s[X_W] ? DELTA_W'(-dx_s) : DELTA_W'(dx_s);
  assign dy_abs = dy_s[Y_W] ? DELTA_W'(-dy_s) : DELTA_W'(dy_s);

  assign hit = (func_q == bcr_pkg::FUNC_RING_SET) ? (dist_hit.in_circle & dist_hit.in_band)
                                                  : dist_hit.in_circle;

  bcr_dist u_dist (
    .mul_a_i (mul_a),
    .mul_b_i (mul_b),
    .rr_i    (rr_q),
    .dy2_i   (dy2_q),
    .band_i  (band_q),
    .prod_o  (prod),
    .hit_o   (dist_hit)
  );

  bcr_store #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcr_pkg::ST_CLEAR: begin
        if (clr_q == AW'(STORE_BYTES - 1)) begin
          state_d = bcr_pkg::ST_IDLE;
        end
      end
      bcr_pkg::ST_IDLE: begin
        if (accept && is_draw && !box_empty) begin
          state_d = bcr_pkg::ST_RR;
        end else if (accept && is_read) begin
          state_d = bcr_pkg::ST_RESP;
        end
      end
      bcr_pkg::ST_RR:   state_d = bcr_pkg::ST_BAND;
      bcr_pkg::ST_BAND: state_d = bcr_pkg::ST_BASE;
      bcr_pkg::ST_BASE: state_d = bcr_pkg::ST_ROW;
      bcr_pkg::ST_ROW:  state_d = bcr_pkg::ST_RD;
      bcr_pkg::ST_RD:   state_d = bcr_pkg::ST_LD;
      bcr_pkg::ST_LD:   state_d = bcr_pkg::ST_PIX;
      bcr_pkg::ST_PIX: begin
        if (byte_end) begin
          state_d = bcr_pkg::ST_WR;
        end
      end
      bcr_pkg::ST_WR: begin
        if (!row_end) begin
          state_d = bcr_pkg::ST_RD;
        end else if (y_q == y1_q) begin
          state_d = bcr_pkg::ST_IDLE;
        end else begin
          state_d = bcr_pkg::ST_ROW;
        end
      end
      bcr_pkg::ST_RESP: state_d = bcr_pkg::ST_IDLE;
      default:          state_d = bcr_pkg::ST_IDLE;
    endcase
  end

  // Memory ports, multiplier operands and the result strobe
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = byte_idx;
    mem_wdata    = work_q;
    mem_re       = 1'b0;
    mem_raddr    = byte_idx;
    mul_a        = MUL_W'(dx_abs);
    mul_b        = MUL_W'(dx_abs);
    read_valid_o = 1'b0;
    unique case (state_q)
      bcr_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      bcr_pkg::ST_IDLE: begin
        // Byte access goes straight to the store on the transfer edge
        mem_we    = accept && is_write && addr_ok;
        mem_waddr = AW'(byte_address_i);
        mem_wdata = write_byte_i;
        mem_re    = accept && is_read && addr_ok;
        mem_raddr = AW'(byte_address_i);
      end
      bcr_pkg::ST_RR: begin
        mul_a = MUL_W'(r_q);
        mul_b = MUL_W'(r_q);
      end
      bcr_pkg::ST_BAND: begin
        mul_a = MUL_W'(r_q);
        mul_b = MUL_W'(t_q);
      end
      bcr_pkg::ST_BASE: begin
        mul_a = MUL_W'(y_q);
        mul_b = MUL_W'(IMAGE_WIDTH);
      end
      bcr_pkg::ST_ROW: begin
        mul_a = MUL_W'(dy_abs);
        mul_b = MUL_W'(dy_abs);
      end
      bcr_pkg::ST_RD:   mem_re = 1'b1;
      bcr_pkg::ST_LD:   ;
      bcr_pkg::ST_PIX:  ;
      bcr_pkg::ST_WR:   mem_we = 1'b1;
      bcr_pkg::ST_RESP: read_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign read_byte_o = rd_ok_q ? mem_rdata : 8'h00;

  // Datapath registers
  always_comb begin
    clr_d   = clr_q;
    func_d  = func_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    r_d     = r_q;
    t_d     = t_q;
    x0_d    = x0_q;
    x1_d    = x1_q;
    x_d     = x_q;
    y1_d    = y1_q;
    y_d     = y_q;
    rd_ok_d = rd_ok_q;
    rr_d    = rr_q;
    band_d  = band_q;
    dy2_d   = dy2_q;
    base_d  = base_q;
    work_d  = work_q;
    unique case (state_q)
      bcr_pkg::ST_CLEAR: clr_d = clr_q + AW'(1);
      bcr_pkg::ST_IDLE: begin
        if (accept) begin
          func_d  = func_i;
          cx_d    = center_x_i;
          cy_d    = center_y_i;
          r_d     = radius_i;
          t_d     = ring_thickness_i;
          x0_d    = x0_in;
          x1_d    = x1_in;
          y_d     = y0_in;
          y1_d    = y1_in;
          rd_ok_d = addr_ok;
        end
      end
      bcr_pkg::ST_RR:   rr_d   = prod[SQ_W-1:0];
      bcr_pkg::ST_BAND: band_d = {prod[SQ_W-2:0], 1'b0};
      bcr_pkg::ST_BASE: base_d = prod[PW-1:0];
      bcr_pkg::ST_ROW: begin
        dy2_d = prod[SQ_W-1:0];
        x_d   = x0_q;
      end
      bcr_pkg::ST_RD: ;
      bcr_pkg::ST_LD: work_d = mem_rdata;
      bcr_pkg::ST_PIX: begin
        if (hit) begin
          work_d[bit_sel] = (func_q == bcr_pkg::FUNC_FILL_TOG) ? ~work_q[bit_sel] : 1'b1;
        end
        // Hold x at a byte boundary so the write-back sees the same byte
        if (!byte_end) begin
          x_d = x_q + X_W'(1);
        end
      end
      bcr_pkg::ST_WR: begin
        if (!row_end) begin
          x_d = x_q + X_W'(1);
        end else if (y_q != y1_q) begin
          y_d    = y_q + Y_W'(1);
          base_d = base_q + PW'(IMAGE_WIDTH);
        end
      end
      bcr_pkg::ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcr_pkg::ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    r_q     <= r_d;
    t_q     <= t_d;
    x0_q    <= x0_d;
    x1_q    <= x1_d;
    x_q     <= x_d;
    y1_q    <= y1_d;
    y_q     <= y_d;
    rd_ok_q <= rd_ok_d;
    rr_q    <= rr_d;
    band_q  <= band_d;
    dy2_q   <= dy2_d;
    base_q  <= base_d;
    work_q  <= work_d;
  end

  // A read transfer gives its result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_read) |=> read_valid_o)
    else $error("read transfer without result strobe");

  // One strobe per read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |=> !read_valid_o)
    else $error("result strobe longer than one cycle");

  // A draw with a visible box keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_draw && !box_empty) |=> busy)
    else $error("draw transfer did not start the walk");

  // The walk stays inside the clipped box
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcr_pkg::ST_PIX) |-> (x_q >= x0_q && x_q <= x1_q && y_q <= y1_q))
    else $error("walk left the clipped box");

  // Every visited pixel lies inside the image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bcr_pkg::ST_PIX) |-> (int'(pix) < NPIX))
    else $error("pixel index past the image");

endmodule
